// ===== hw/rtl/bpr_pkg.sv =====
// shared constants, types and tables for the phase rotator bank
// no dependencies
`default_nettype none
package bpr_pkg;
  localparam int unsigned WaveChannels = 16;
  localparam int unsigned FieldBits = 16;
  localparam int unsigned WaveBits = 4;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AccBits = 34;
  localparam logic [15:0] InvCordicGain = 16'd39797;

  localparam logic [1:0] CmdPort0 = 2'd0;
  localparam logic [1:0] CmdPort1 = 2'd1;
  localparam logic [1:0] CmdVolt = 2'd2;
  localparam logic [1:0] CmdNop = 2'd3;

  localparam logic CfgGain = 1'b0;
  localparam logic CfgSens = 1'b1;

  typedef struct packed {
    logic                 port;
    logic [WaveBits-1:0]  wave;
    logic                 last;
  } tag_t;

  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] r;
    case (i)
      4'd0: r = 14'd8192;
      4'd1: r = 14'd4836;
      4'd2: r = 14'd2555;
      4'd3: r = 14'd1297;
      4'd4: r = 14'd651;
      4'd5: r = 14'd326;
      4'd6: r = 14'd163;
      4'd7: r = 14'd81;
      4'd8: r = 14'd41;
      4'd9: r = 14'd20;
      4'd10: r = 14'd10;
      4'd11: r = 14'd5;
      4'd12: r = 14'd3;
      4'd13: r = 14'd1;
      4'd14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/bpr_field_ram.sv =====
// field store: both port tables in one synchronous ram with a registered read
// depends on bpr_pkg
`default_nettype none
module bpr_field_ram (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [bpr_pkg::WaveBits:0]          waddr_i,
  input  wire logic [2*bpr_pkg::FieldBits-1:0]     wdata_i,
  input  wire logic [bpr_pkg::WaveBits:0]          raddr_i,
  output logic      [2*bpr_pkg::FieldBits-1:0]     rdata_o
);
  logic [2*bpr_pkg::FieldBits-1:0] mem [2*bpr_pkg::WaveChannels];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bpr_rotator.sv =====
// iterative cordic rotator with gain scaling and saturation, one item at a time
// depends on bpr_pkg
`default_nettype none
module bpr_rotator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [bpr_pkg::FieldBits-1:0] re_i,
  input  wire logic signed [bpr_pkg::FieldBits-1:0] im_i,
  input  wire logic [15:0]                         phase_i,
  input  wire logic [15:0]                         gain_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output logic signed [bpr_pkg::FieldBits-1:0]     re_o,
  output logic signed [bpr_pkg::FieldBits-1:0]     im_o
);
  localparam int unsigned AB = bpr_pkg::AccBits;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIter = 2'd1;
  localparam logic [1:0] StMul = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0] st_q, st_d;
  logic [3:0] it_q;
  logic signed [AB-1:0] x_q, y_q;
  logic signed [16:0] r_q;
  logic [16:0] kg_q;
  logic signed [AB+17:0] px_q, py_q;

  logic [1:0] q;
  logic [15:0] rw;
  logic signed [AB-1:0] a, b, dx, dy;
  logic [32:0] kgw;

  assign q = 2'((phase_i + 16'd8192) >> 14);
  assign rw = phase_i - {q, 14'd0};
  assign a = AB'(re_i) <<< 14;
  assign b = AB'(im_i) <<< 14;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign kgw = (33'(gain_i) * 33'(bpr_pkg::InvCordicGain) + 33'd32768) >> 16;

  function automatic logic signed [bpr_pkg::FieldBits-1:0] sat(
      input logic signed [AB+17:0] p);
    logic signed [AB+17:0] v;
    logic signed [AB+17:0] hi, lo;
    v = (p + (AB+18)'(64'sd1 <<< 29)) >>> 30;
    hi = (AB+18)'((64'sd1 <<< (bpr_pkg::FieldBits-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[bpr_pkg::FieldBits-1:0];
    if (v < lo) return lo[bpr_pkg::FieldBits-1:0];
    return v[bpr_pkg::FieldBits-1:0];
  endfunction

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (start_i) st_d = StIter;
      StIter: if (it_q == 4'd15) st_d = StMul;
      StMul:  st_d = StOut;
      StOut:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start_i) begin
      it_q <= 4'd0;
      r_q <= 17'(signed'(rw));
      kg_q <= kgw[16:0];
      case (q)
        2'd0: begin x_q <= a;  y_q <= b;  end
        2'd1: begin x_q <= -b; y_q <= a;  end
        2'd2: begin x_q <= -a; y_q <= -b; end
        default: begin x_q <= b; y_q <= -a; end
      endcase
    end else if (st_q == StIter) begin
      it_q <= it_q + 4'd1;
      if (!r_q[16]) begin
        x_q <= x_q - dx; y_q <= y_q + dy;
        r_q <= r_q - 17'(bpr_pkg::atan_lut(it_q));
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy;
        r_q <= r_q + 17'(bpr_pkg::atan_lut(it_q));
      end
    end else if (st_q == StMul) begin
      px_q <= (AB+18)'(x_q) * (AB+18)'(signed'({1'b0, kg_q}));
      py_q <= (AB+18)'(y_q) * (AB+18)'(signed'({1'b0, kg_q}));
    end else if (st_q == StOut) begin
      re_o <= sat(px_q);
      im_o <= sat(py_q);
    end
  end

  assign busy_o = st_q != StIdle;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= st_q == StOut;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bidirectional_phase_rotator_bank.sv =====
// top level of the two-port phase rotator bank: control, valid bits, output register
// depends on bpr_pkg, bpr_field_ram, bpr_rotator
//
// in channel: cmd_i 0/1 stores a field item under wave_index_i in the table of
// that port and sends it rotated out of the other port; cmd_i 2 sets the phase
// to phase_sensitivity * drive_voltage_i and resends every stored port 0 entry
// toward port 1, then every port 1 entry toward port 0, ascending wavelength.
// cmd_i 3 is dropped without result.
// each result goes through a 16 step iterative cordic plus a multiply and a
// saturate stage; a field item's result is loaded into the output register
// before the next item can be taken.
// a voltage update reads and rotates each stored entry and passes over each
// empty slot; the next item can be taken right after its last result.
// items are handled one at a time; in_ready_o is high only while idle.
// results wait in an output register; while it is full and out_ready_i is low the block holds.
// last_o marks the final result of an input item.
// reset: all ram entries read as zero through per-entry init bits, only
// wavelength 0 valid in both tables, phase zero, gain 65535, sensitivity 0.
// configuration writes are accepted only while idle.
`default_nettype none
module bidirectional_phase_rotator_bank (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic [bpr_pkg::WaveBits-1:0]        wave_index_i,
  input  wire logic signed [bpr_pkg::FieldBits-1:0] in_real_i,
  input  wire logic signed [bpr_pkg::FieldBits-1:0] in_imag_i,
  input  wire logic signed [15:0]                  drive_voltage_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     exit_port_o,
  output logic [bpr_pkg::WaveBits-1:0]             out_wave_o,
  output logic signed [bpr_pkg::FieldBits-1:0]     out_real_o,
  output logic signed [bpr_pkg::FieldBits-1:0]     out_imag_o,
  output logic                                     last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic                                cfg_index_i,
  input  wire logic [15:0]                         cfg_data_i
);
  localparam int unsigned WC = bpr_pkg::WaveChannels;
  localparam int unsigned WB = bpr_pkg::WaveBits;
  localparam int unsigned FB = bpr_pkg::FieldBits;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StRot = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0] st_q;
  logic [15:0] gain_q, sens_q, phase_q;
  logic [WC-1:0] val0_q, val1_q, init0_q, init1_q;
  logic [WB:0] ptr_q;
  logic single_q;
  bpr_pkg::tag_t tag_q;
  logic signed [FB-1:0] fre_q, fim_q;
  logic byp_q;

  logic acc;
  logic [WB:0] waddr;
  logic [2*FB-1:0] rdata;
  logic rot_busy, rot_done;
  logic signed [FB-1:0] rre, rim;
  logic cur_valid;
  logic [WB:0] next_ptr;
  logic more;
  logic [31:0] prod;
  logic entry_init;
  logic out_load;

  assign in_ready_o = st_q == StIdle;
  assign cfg_ready_o = st_q == StIdle;
  assign acc = in_valid_i && in_ready_o;
  assign waddr = {cmd_i[0], wave_index_i};
  assign prod = 32'(signed'(sens_q) * signed'(drive_voltage_i));
  assign out_load = (st_q == StRot && rot_done && !out_valid_o) ||
                    (st_q == StOut && (!out_valid_o || out_ready_i));

  assign cur_valid = ptr_q[WB] ? val1_q[ptr_q[WB-1:0]] : val0_q[ptr_q[WB-1:0]];
  assign entry_init = ptr_q[WB] ? init1_q[ptr_q[WB-1:0]] : init0_q[ptr_q[WB-1:0]];
  assign next_ptr = ptr_q + (WB+1)'(1);

  always_comb begin
    more = 1'b0;
    for (int k = 0; k < 2*WC; k++) begin
      if (k > int'(ptr_q)) begin
        if (k >= WC) more = more | val1_q[k-WC];
        else more = more | val0_q[k];
      end
    end
  end

  bpr_field_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (acc && !cmd_i[1]),
    .waddr_i (waddr),
    .wdata_i ({in_real_i, in_imag_i}),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  bpr_rotator u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == StRot && !rot_busy && !rot_done),
    .re_i    (byp_q ? fre_q : (entry_init ? signed'(rdata[2*FB-1:FB]) : '0)),
    .im_i    (byp_q ? fim_q : (entry_init ? signed'(rdata[FB-1:0]) : '0)),
    .phase_i (phase_q),
    .gain_i  (gain_q),
    .busy_o  (rot_busy),
    .done_o  (rot_done),
    .re_o    (rre),
    .im_o    (rim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      gain_q <= 16'hFFFF;
      sens_q <= '0;
      phase_q <= '0;
      val0_q <= WC'(1);
      val1_q <= WC'(1);
      init0_q <= '0;
      init1_q <= '0;
      ptr_q <= '0;
      out_valid_o <= 1'b0;
      single_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bpr_pkg::CfgGain: gain_q <= cfg_data_i;
          bpr_pkg::CfgSens: sens_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (acc) begin
            if (cmd_i == bpr_pkg::CmdPort0 || cmd_i == bpr_pkg::CmdPort1) begin
              if (cmd_i[0]) begin
                val1_q[wave_index_i] <= 1'b1; init1_q[wave_index_i] <= 1'b1;
              end else begin
                val0_q[wave_index_i] <= 1'b1; init0_q[wave_index_i] <= 1'b1;
              end
              single_q <= 1'b1;
              st_q <= StRot;
            end else if (cmd_i == bpr_pkg::CmdVolt) begin
              phase_q <= prod[15:0];
              ptr_q <= '0;
              single_q <= 1'b0;
              st_q <= StScan;
            end
          end
        end
        StScan: begin
          if (cur_valid) st_q <= StRead;
          else if (ptr_q == (WB+1)'(2*WC-1)) st_q <= StIdle;
          else ptr_q <= next_ptr;
        end
        StRead: st_q <= StRot;
        StRot: begin
          if (rot_done && !out_valid_o) begin
            if (single_q || !more) st_q <= StIdle;
            else begin
              ptr_q <= next_ptr;
              st_q <= StScan;
            end
          end else if (rot_done) begin
            st_q <= StOut;
          end
        end
        StOut: begin
          if (!out_valid_o || out_ready_i) begin
            if (single_q || !more) st_q <= StIdle;
            else begin
              ptr_q <= next_ptr;
              st_q <= StScan;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fre_q <= in_real_i;
      fim_q <= in_imag_i;
      byp_q <= !cmd_i[1];
      tag_q <= '{port: !cmd_i[0], wave: wave_index_i, last: 1'b1};
    end else if (st_q == StScan && cur_valid) begin
      byp_q <= 1'b0;
      tag_q <= '{port: !ptr_q[WB], wave: ptr_q[WB-1:0], last: 1'b0};
    end
    if (out_load) begin
      exit_port_o <= tag_q.port;
      out_wave_o <= tag_q.wave;
      last_o <= single_q || !more;
      out_real_o <= rre;
      out_imag_o <= rim;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_bidirectional_phase_rotator_bank.sv =====
// self-checking testbench for the two-port phase rotator bank
// predicts rotated, scaled results in a scoreboard class; depends on bpr_pkg and the rtl
`default_nettype none
module tb_bidirectional_phase_rotator_bank;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        port;
    logic [3:0]  wave;
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
  } rot_res_t;

  class rotator_scoreboard;
    logic [15:0] gain;
    logic [15:0] sens;
    logic [15:0] phase;
    logic signed [15:0] re0 [16];
    logic signed [15:0] im0 [16];
    logic signed [15:0] re1 [16];
    logic signed [15:0] im1 [16];
    logic [15:0] vld0;
    logic [15:0] vld1;
    rot_res_t pending[$];
    int errors;
    int checked;

    function new();
      gain = 16'hffff;
      sens = 16'h0000;
      phase = 16'h0000;
      vld0 = 16'h0001;
      vld1 = 16'h0001;
      errors = 0;
      checked = 0;
      for (int i = 0; i < 16; i++) begin
        re0[i] = '0; im0[i] = '0; re1[i] = '0; im1[i] = '0;
      end
    endfunction

    function automatic longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic logic [15:0] sat16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function automatic rot_res_t rotate(logic port, logic [3:0] wave,
                                        logic signed [15:0] re, logic signed [15:0] im);
      rot_res_t o;
      logic [1:0] q;
      logic [15:0] rr;
      longint r, a, b, x, y, dx, dy, kg;
      longint atan_tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                41, 20, 10, 5, 3, 1, 1, 0};
      q = 2'((32'(phase) + 32'd8192) >> 14);
      rr = phase - 16'(q) * 16'd16384;
      r = longint'($signed(rr));
      a = longint'(re) * 16384;
      b = longint'(im) * 16384;
      case (q)
        2'd0: begin x = a; y = b; end
        2'd1: begin x = -b; y = a; end
        2'd2: begin x = -a; y = -b; end
        default: begin x = b; y = -a; end
      endcase
      for (int i = 0; i < 16; i++) begin
        dx = fshr(y, i);
        dy = fshr(x, i);
        if (r >= 0) begin
          x -= dx; y += dy; r -= atan_tab[i];
        end else begin
          x += dx; y -= dy; r += atan_tab[i];
        end
      end
      kg = (longint'(gain) * 39797 + 32768) >>> 16;
      o.port = port;
      o.wave = wave;
      o.re = sat16(fshr(x * kg + (longint'(1) << 29), 30));
      o.im = sat16(fshr(y * kg + (longint'(1) << 29), 30));
      o.last = 1'b0;
      return o;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == bpr_pkg::CfgGain) gain = val;
      else sens = val;
    endfunction

    function void note_item(logic [1:0] cmd, logic [3:0] wave, logic signed [15:0] re,
                            logic signed [15:0] im, logic signed [15:0] volt);
      rot_res_t o;
      int n;
      longint p;
      if (cmd == bpr_pkg::CmdPort0) begin
        re0[wave] = re; im0[wave] = im; vld0[wave] = 1'b1;
        o = rotate(1'b1, wave, re, im);
        o.last = 1'b1;
        pending.push_back(o);
      end else if (cmd == bpr_pkg::CmdPort1) begin
        re1[wave] = re; im1[wave] = im; vld1[wave] = 1'b1;
        o = rotate(1'b0, wave, re, im);
        o.last = 1'b1;
        pending.push_back(o);
      end else if (cmd == bpr_pkg::CmdVolt) begin
        p = longint'($signed(sens)) * longint'(volt);
        phase = p[15:0];
        n = 0;
        for (int w = 0; w < 16; w++)
          if (vld0[w]) begin
            pending.push_back(rotate(1'b1, 4'(w), re0[w], im0[w])); n++;
          end
        for (int w = 0; w < 16; w++)
          if (vld1[w]) begin
            pending.push_back(rotate(1'b0, 4'(w), re1[w], im1[w])); n++;
          end
        if (n > 0) pending[$].last = 1'b1;
      end
    endfunction

    function void check_result(rot_res_t got);
      rot_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic [3:0] wave_index_i = '0;
  logic signed [15:0] in_real_i = '0;
  logic signed [15:0] in_imag_i = '0;
  logic signed [15:0] drive_voltage_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic exit_port_o;
  logic [3:0] out_wave_o;
  logic signed [15:0] out_real_o;
  logic signed [15:0] out_imag_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  rotator_scoreboard sb = new();
  int idle_cycles = 0;
  int hold_off = 0;
  int items_sent = 0;
  bit stim_done = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_seen = 1'b0;

  always #10 clk_i = ~clk_i;

  bidirectional_phase_rotator_bank u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .wave_index_i, .in_real_i,
    .in_imag_i, .drive_voltage_i, .out_valid_o, .out_ready_i, .exit_port_o,
    .out_wave_o, .out_real_o, .out_imag_o, .last_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_item(cmd_i, wave_index_i, in_real_i, in_imag_i, drive_voltage_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{exit_port_o, out_wave_o, out_real_o, out_imag_o, last_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("bidirectional_phase_rotator_bank regression: fail");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold_req && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      hold_off <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (stim_done || items_sent < 25) begin
      out_ready_i <= 1'b1;
    end else begin
      case ((items_sent / 40) % 3)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [3:0] wave, logic [15:0] re,
                           logic [15:0] im, logic [15:0] volt);
    @(negedge clk_i);
    cmd_i <= cmd;
    wave_index_i <= wave;
    in_real_i <= re;
    in_imag_i <= im;
    drive_voltage_i <= volt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    items_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    wait_drained();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [1:0] cmd;
    int k;
    k = $urandom_range(0, 19);
    if (k < 8) cmd = bpr_pkg::CmdPort0;
    else if (k < 16) cmd = bpr_pkg::CmdPort1;
    else if (k < 19) cmd = bpr_pkg::CmdVolt;
    else cmd = bpr_pkg::CmdNop;
    send_item(cmd, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // reset state: only wavelength 0 stored, zero field
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'd0);
    send_item(bpr_pkg::CmdPort0, 4'd0, 16'h7fff, 16'h7fff, 16'hffff);
    send_item(bpr_pkg::CmdPort0, 4'd15, 16'h8000, 16'h8000, 16'd0);
    send_item(bpr_pkg::CmdPort1, 4'd15, 16'h7fff, 16'h8000, 16'h8000);
    send_item(bpr_pkg::CmdPort1, 4'd7, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(bpr_pkg::CmdNop, 4'd9, 16'h1234, 16'h5678, 16'h9abc);
    send_item(bpr_pkg::CmdVolt, 4'd3, 16'hffff, 16'hffff, 16'h7fff);
    write_cfg(bpr_pkg::CfgSens, 16'h7fff);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'h7fff);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'h8000);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'd1);
    write_cfg(bpr_pkg::CfgSens, 16'h8000);
    write_cfg(bpr_pkg::CfgGain, 16'd0);
    send_item(bpr_pkg::CmdPort0, 4'd3, 16'h7fff, 16'h0000, 16'd0);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'h8000);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'hffff);
    write_cfg(bpr_pkg::CfgSens, 16'h4000);
    write_cfg(bpr_pkg::CfgGain, 16'hffff);
    for (int w = 0; w < 16; w++)
      send_item(bpr_pkg::CmdPort0, 4'(w), 16'($urandom), 16'($urandom), 16'd0);
    for (int w = 0; w < 16; w++)
      send_item(bpr_pkg::CmdPort1, 4'(w), 16'($urandom), 16'($urandom), 16'd0);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'd1);
    send_item(bpr_pkg::CmdVolt, 4'd0, 16'd0, 16'd0, 16'd3);
    // long receiver hold-off while items keep coming
    long_hold_req = 1'b1;
    for (int i = 0; i < 10; i++) random_item();
    wait_drained();
    for (int phase_n = 0; phase_n < 4; phase_n++) begin
      write_cfg(bpr_pkg::CfgGain, 16'($urandom));
      write_cfg(bpr_pkg::CfgSens, 16'($urandom));
      for (int i = 0; i < 10; i++) begin
        burst = $urandom_range(1, 8);
        for (int j = 0; j < burst; j++) random_item();
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
    wait_drained();
    stim_done = 1'b1;
    $display("run covered %0d input items, %0d results checked, gain and sensitivity",
             items_sent, sb.checked);
    $display("swept over extremes and random settings with input and output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bidirectional_phase_rotator_bank regression: pass");
    else
      $display("bidirectional_phase_rotator_bank regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
